>>> rtl/core/clr_pkg.sv
`default_nettype none
package clr_pkg;

  // Largest grid side; wider register values are clamped to it
  localparam int GRID_MAX = 64;

  // Datapath widths
  localparam int CW  = 24;            // cell coordinate and fraction width
  localparam int PW  = 2 * CW;        // product and dividend width
  localparam int QW  = 22;            // divider quotient width
  localparam int SW  = 5;             // divider step count width
  localparam int GW  = 6;             // grid coordinate width
  localparam int EW  = 10;            // Bresenham error term width

  // Divider step counts and divisor alignment
  localparam int MAP_STEPS = 22;
  localparam int RND_STEPS = 7;

  // Register indexes
  typedef enum logic [1:0] {
    REG_COLS = 2'd0,
    REG_ROWS = 2'd1,
    REG_PXW  = 2'd2,
    REG_PXH  = 2'd3
  } reg_idx_t;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MAP_MUL,
    ST_MAP_DIV,
    ST_MAP_WAIT,
    ST_CLIP_EDGE,
    ST_CMP_A,
    ST_CMP_B,
    ST_CMP_C,
    ST_RND_A,
    ST_RND_B,
    ST_RND_DIV,
    ST_RND_WAIT,
    ST_LINE_SETUP,
    ST_LINE
  } state_t;

  // Divider request
  typedef struct packed {
    logic          start;
    logic [SW-1:0] steps;
  } div_req_t;

  // Divider response
  typedef struct packed {
    logic          done;
    logic          busy;
    logic          rem_nz;
  } div_rsp_t;

endpackage
`default_nettype wire

>>> rtl/core/clr_div.sv
`default_nettype none
module clr_div
  import clr_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire div_req_t      req,
  input  wire logic [PW-1:0] dividend,
  input  wire logic [PW-1:0] divisor,   // already aligned to the top quotient bit
  output div_rsp_t           rsp,
  output logic [QW-1:0]      quo
);

  logic [PW-1:0] rem;
  logic [PW-1:0] dsh;
  logic [SW-1:0] cnt;
  logic          busy;
  logic          done;
  logic          fits;

  assign fits = (rem >= dsh);

  // Control: step counter and done pulse
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= req.steps;
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == SW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Restoring division, one quotient bit a cycle
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= dividend;
      dsh <= divisor;
      quo <= '0;
    end else if (busy) begin
      if (fits) rem <= rem - dsh;
      dsh <= dsh >> 1;
      quo <= {quo[QW-2:0], fits};
    end
  end

  assign rsp.done   = done;
  assign rsp.busy   = busy;
  assign rsp.rem_nz = (rem != '0);

endmodule
`default_nettype wire

>>> rtl/core/clipped_line_rasterizer_top.sv
`default_nettype none
// Endpoint mapping is bound by the serial divider (four endpoints, one division each);
// clipping runs its compares on the shared 24x24 multiplier; end rounding divides once
// per end (four ends); then one cell a cycle, while m_tready allows, for up to 64 cells.
// Order of work from one accepted command to the next: accept, map, clip, round, set-up
// state, line; a rejected line returns to idle sooner.
// A new line is taken once the last cell is loaded into the output register.
// Reset (synchronous, rst high): sequencer idle, output empty, registers 64/64/512/512.
module clipped_line_rasterizer_top
  import clr_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // start_x[15:0], start_y[31:16], end_x[47:32], end_y[63:48],
  // red_in[71:64], green_in[79:72], blue_in[87:80]
  input  wire logic [87:0] s_tdata,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // cell_x[5:0], cell_y[11:6], red_out[19:12], green_out[27:20], blue_out[35:28], zero pad
  output logic [39:0]      m_tdata,
  output logic             m_tlast,   // last_cell
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  // Configuration registers
  logic [6:0]  cols;
  logic [6:0]  rows;
  logic [15:0] pxw;
  logic [15:0] pxh;

  always_ff @(posedge clk) begin
    if (rst) begin
      cols <= 7'd64;
      rows <= 7'd64;
      pxw  <= 16'd512;
      pxh  <= 16'd512;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_COLS: cols <= cfg_data[6:0];
        REG_ROWS: rows <= cfg_data[6:0];
        REG_PXW:  pxw  <= cfg_data;
        REG_PXH:  pxh  <= cfg_data;
        default:  ;
      endcase
    end
  end

  logic [6:0] cols_eff;
  logic [6:0] rows_eff;
  assign cols_eff = (cols > 7'(GRID_MAX)) ? 7'(GRID_MAX) : cols;
  assign rows_eff = (rows > 7'(GRID_MAX)) ? 7'(GRID_MAX) : rows;

  // Command and working registers
  state_t                state, state_next;
  logic [15:0]           pin [4];
  logic [7:0]            red, green, blue;
  logic signed [CW-1:0]  ax, ay, bx, by;
  logic signed [CW-1:0]  lo_n, lo_d, hi_n, hi_d;
  logic [1:0]            idx;       // endpoint, edge or end counter
  logic                  second;    // second compare of an edge
  logic                  map_neg;
  logic signed [PW-1:0]  mres;
  logic signed [PW-1:0]  prod_a;
  logic [GW-1:0]         x0, y0, x1, y1;
  logic [GW-1:0]         adx, ady;
  logic                  sx, sy;
  logic signed [EW-1:0]  err;
  logic [GW-1:0]         cnt;

  // Shared multiplier, registered
  logic signed [CW-1:0] mul_a, mul_b;
  always_ff @(posedge clk) begin
    mres <= mul_a * mul_b;
  end

  // Shared divider
  div_req_t       dreq;
  div_rsp_t       drsp;
  logic [PW-1:0]  div_dividend, div_divisor;
  logic [QW-1:0]  dquo;

  clr_div u_div (
    .clk      (clk),
    .rst      (rst),
    .req      (dreq),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .rsp      (drsp),
    .quo      (dquo)
  );

  // Endpoint mapping operands
  logic               map_is_y;
  logic signed [CW-1:0] map_p;
  assign map_is_y = idx[0];
  assign map_p    = CW'(signed'(pin[idx]));

  // Clip edge operands
  logic signed [CW-1:0] dx, dy, ep, eq, r_n, r_d;
  logic signed [CW-1:0] x_n, x_d, y_n, y_d;
  logic                 p_neg, p_zero;
  assign dx = bx - ax;
  assign dy = by - ay;

  always_comb begin
    case (idx)
      2'd0:    begin ep = -dx; eq = ax; end
      2'd1:    begin ep = dx;  eq = CW'(signed'({1'b0, cols_eff})) - CW'(1) - ax; end
      2'd2:    begin ep = -dy; eq = ay; end
      default: begin ep = dy;  eq = CW'(signed'({1'b0, rows_eff})) - CW'(1) - ay; end
    endcase
  end

  assign p_neg  = ep[CW-1];
  assign p_zero = (ep == '0);
  assign r_n    = p_neg ? -eq : eq;
  assign r_d    = p_neg ? -ep : ep;

  // Fraction compare X > Y, picked by edge direction and compare phase
  always_comb begin
    if (p_neg) begin
      x_n = r_n; x_d = r_d;
      y_n = second ? lo_n : hi_n;
      y_d = second ? lo_d : hi_d;
    end else begin
      x_n = second ? hi_n : lo_n;
      x_d = second ? hi_d : lo_d;
      y_n = r_n; y_d = r_d;
    end
  end

  logic cmp_gt;
  assign cmp_gt = (prod_a > mres);

  // Rounding operands: far end first, then near end
  logic signed [CW-1:0] rc, rd, fn, fd;
  logic signed [PW-1:0] rnd_n;
  assign rc    = idx[0] ? ay : ax;
  assign rd    = idx[0] ? dy : dx;
  assign fn    = idx[1] ? lo_n : hi_n;
  assign fd    = idx[1] ? lo_d : hi_d;
  assign rnd_n = prod_a + mres;

  // Bresenham step, signed compares on the error term
  logic                 line_load, line_done;
  logic signed [EW-1:0] e2, err_next;
  logic signed [EW-1:0] adx_s, ady_s;
  logic                 step_x, step_y;
  assign line_load = (state == ST_LINE) && (!m_tvalid || m_tready);
  assign line_done = ((x0 == x1) && (y0 == y1)) || (cnt == GW'(GRID_MAX - 1));
  assign adx_s     = EW'(adx);
  assign ady_s     = EW'(ady);
  assign e2        = err <<< 1;
  assign step_x    = (e2 > -ady_s);
  assign step_y    = (e2 < adx_s);
  assign err_next  = err - (step_x ? ady_s : EW'(0)) + (step_y ? adx_s : EW'(0));

  logic zero_cfg;
  assign zero_cfg = (cols == '0) || (rows == '0) || (pxw == '0) || (pxh == '0);

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:       if (s_tvalid && !zero_cfg) state_next = ST_MAP_MUL;
      ST_MAP_MUL:    state_next = ST_MAP_DIV;
      ST_MAP_DIV:    state_next = ST_MAP_WAIT;
      ST_MAP_WAIT:   if (drsp.done) state_next = (idx == 2'd3) ? ST_CLIP_EDGE : ST_MAP_MUL;
      ST_CLIP_EDGE: begin
        if (!p_zero)        state_next = ST_CMP_A;
        else if (eq[CW-1])  state_next = ST_IDLE;
        else if (idx == 2'd3) state_next = ST_RND_A;
      end
      ST_CMP_A:      state_next = ST_CMP_B;
      ST_CMP_B:      state_next = ST_CMP_C;
      ST_CMP_C: begin
        if (!second)          state_next = cmp_gt ? ST_IDLE : ST_CMP_A;
        else if (idx == 2'd3) state_next = ST_RND_A;
        else                  state_next = ST_CLIP_EDGE;
      end
      ST_RND_A:      state_next = ST_RND_B;
      ST_RND_B:      state_next = ST_RND_DIV;
      ST_RND_DIV:    state_next = ST_RND_WAIT;
      ST_RND_WAIT:   if (drsp.done) state_next = (idx == 2'd3) ? ST_LINE_SETUP : ST_RND_A;
      ST_LINE_SETUP: state_next = ST_LINE;
      ST_LINE:       if (line_load && line_done) state_next = ST_IDLE;
      default:       state_next = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer: multiplier, divider and input handshake
  always_comb begin
    s_tready     = 1'b0;
    mul_a        = '0;
    mul_b        = '0;
    dreq.start   = 1'b0;
    dreq.steps   = SW'(MAP_STEPS);
    div_dividend = mres[PW-1] ? PW'(-mres) : PW'(mres);
    div_divisor  = {11'd0, (map_is_y ? pxh : pxw), 21'd0};
    unique case (state)
      ST_IDLE:    s_tready = 1'b1;
      ST_MAP_MUL: begin
        mul_a = map_p;
        mul_b = CW'(signed'({1'b0, map_is_y ? rows_eff : cols_eff}));
      end
      ST_MAP_DIV: dreq.start = 1'b1;
      ST_CMP_A:   begin mul_a = x_n; mul_b = y_d; end
      ST_CMP_B:   begin mul_a = y_n; mul_b = x_d; end
      ST_RND_A:   begin mul_a = rc;  mul_b = fd;  end
      ST_RND_B:   begin mul_a = fn;  mul_b = rd;  end
      ST_RND_DIV: begin
        dreq.start   = 1'b1;
        dreq.steps   = SW'(RND_STEPS);
        div_dividend = PW'({rnd_n[PW-2:0], 1'b0}) + PW'(unsigned'(fd));
        div_divisor  = {17'd0, fd, 7'd0};
      end
      default: ;
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  // Datapath registers
  logic signed [CW-1:0] map_q;
  assign map_q = map_neg ? -CW'(dquo) - CW'(drsp.rem_nz) : CW'(dquo);

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: if (s_tvalid) begin
        pin[0] <= s_tdata[15:0];
        pin[1] <= s_tdata[31:16];
        pin[2] <= s_tdata[47:32];
        pin[3] <= s_tdata[63:48];
        red    <= s_tdata[71:64];
        green  <= s_tdata[79:72];
        blue   <= s_tdata[87:80];
        lo_n   <= '0;
        lo_d   <= CW'(1);
        hi_n   <= CW'(1);
        hi_d   <= CW'(1);
        idx    <= '0;
        second <= 1'b0;
      end
      ST_MAP_DIV: map_neg <= mres[PW-1];
      ST_MAP_WAIT: if (drsp.done) begin
        case (idx)
          2'd0:    ax <= map_q;
          2'd1:    ay <= map_q;
          2'd2:    bx <= map_q;
          default: by <= map_q;
        endcase
        idx <= idx + 1'b1;
      end
      ST_CLIP_EDGE: if (p_zero) idx <= idx + 1'b1;
      ST_CMP_B: prod_a <= mres;
      ST_CMP_C: begin
        if (!second) begin
          second <= 1'b1;
        end else begin
          second <= 1'b0;
          idx    <= idx + 1'b1;
          if (cmp_gt) begin
            if (p_neg) begin lo_n <= r_n; lo_d <= r_d; end
            else       begin hi_n <= r_n; hi_d <= r_d; end
          end
        end
      end
      ST_RND_B: prod_a <= mres;
      ST_RND_WAIT: if (drsp.done) begin
        case (idx)
          2'd0:    x1 <= dquo[GW-1:0];
          2'd1:    y1 <= dquo[GW-1:0];
          2'd2:    x0 <= dquo[GW-1:0];
          default: y0 <= dquo[GW-1:0];
        endcase
        idx <= idx + 1'b1;
      end
      ST_LINE_SETUP: begin
        adx <= (x1 > x0) ? x1 - x0 : x0 - x1;
        ady <= (y1 > y0) ? y1 - y0 : y0 - y1;
        sx  <= (x0 < x1);
        sy  <= (y0 < y1);
        err <= EW'((x1 > x0) ? x1 - x0 : x0 - x1) - EW'((y1 > y0) ? y1 - y0 : y0 - y1);
        cnt <= '0;
      end
      ST_LINE: if (line_load) begin
        cnt <= cnt + 1'b1;
        err <= err_next;
        if (step_x) x0 <= sx ? x0 + 1'b1 : x0 - 1'b1;
        if (step_y) y0 <= sy ? y0 + 1'b1 : y0 - 1'b1;
      end
      default: ;
    endcase
  end

  // Output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (line_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (line_load) begin
      m_tdata <= {4'd0, blue, green, red, y0, x0};
      m_tlast <= line_done;
    end
  end

  // Checks
  assert property (@(posedge clk) disable iff (rst) (state == ST_IDLE) |-> !drsp.busy)
    else $error("divider busy while idle");

  assert property (@(posedge clk) disable iff (rst)
    (state == ST_CMP_A || state == ST_CMP_B || state == ST_CMP_C ||
     state == ST_CLIP_EDGE) |-> (!lo_n[CW-1] && (hi_n <= hi_d)))
    else $error("clip interval left [0,1]");

  assert property (@(posedge clk) disable iff (rst) (line_load && line_done) |=>
    (state == ST_IDLE && m_tvalid && m_tlast))
    else $error("final cell did not end the line");

endmodule
`default_nettype wire
